@@ rtl/dfn_pkg.sv @@
// ---------------------------------------------------------------------------
// dfn_pkg
// Shared codes and default sizes for the directional focus navigator.
// ---------------------------------------------------------------------------
package dfn_pkg;

   // default sizing
   localparam int DefNodes      = 16;
   localparam int DefCoordBits  = 12;

   // fixed field widths
   localparam int CMD_W   = 3;
   localparam int INDEX_W = 4;
   localparam int DIR_W   = 3;

   // command codes
   localparam logic [CMD_W-1:0] CMD_REGISTER   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_UNREGISTER = 3'd1;
   localparam logic [CMD_W-1:0] CMD_SET_RECT   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SET_FOCUS  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd4;
   localparam logic [CMD_W-1:0] CMD_MOVE       = 3'd5;

   // move directions
   localparam logic [DIR_W-1:0] DIR_UP    = 3'd0;
   localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd1;
   localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd2;
   localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd3;

endpackage

@@ rtl/directional_focus_navigator.sv @@
// ---------------------------------------------------------------------------
// directional_focus_navigator
// Slot table of rectangles with a focus pointer; finds the nearest slot
// ahead of the focused centre (or the bounding box centre) on a move.
// ---------------------------------------------------------------------------
//
//  Port group | Direction | Handshake          | Word
//  -----------+-----------+--------------------+-----------------------------
//  req_*      | in        | req_valid/req_stall| command, index, rect, dir
//  rsp_*      | out       | rsp_valid/rsp_stall| focus state, changed, done
//
//  Every command is taken in the idle state; its result word goes through the
//  done state to the output register once that is free. A move with focus held
//  reads the focused rectangle for the origin, then makes one pass over the
//  rectangle memory for scoring; without focus it makes one pass for the
//  bounding box and one for scoring, one slot read per cycle. Reset
//  (synchronous) clears valid bits and focus; the rectangle memory is not
//  cleared. A stalled result holds in the output register while the next
//  command is taken and worked on.
module directional_focus_navigator
   import dfn_pkg::*;
#(
   parameter int NODES      = DefNodes,
   parameter int COORD_BITS = DefCoordBits
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [CMD_W-1:0]      req_command,
   input  logic [INDEX_W-1:0]    req_entry_index,
   input  logic [COORD_BITS-1:0] req_pos_x,
   input  logic [COORD_BITS-1:0] req_pos_y,
   input  logic [COORD_BITS-1:0] req_size_x,
   input  logic [COORD_BITS-1:0] req_size_y,
   input  logic [DIR_W-1:0]      req_direction,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_focus_valid,
   output logic [INDEX_W-1:0]    rsp_focus_slot,
   output logic                  rsp_focus_changed,
   output logic                  rsp_move_done
);

   localparam int CW        = COORD_BITS;
   localparam int IDX_BITS  = $clog2(NODES);
   localparam int CNT_BITS  = $clog2(NODES + 1);
   localparam int RECT_W    = 4 * CW;
   localparam int OW        = CW + 2;          // doubled centre / origin
   localparam int DW        = CW + 3;          // signed offset
   localparam int SW        = 2 * CW + 4;      // square of an offset
   localparam int SCW       = 2 * CW + 6;      // score

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ORIGIN,
      ST_BBOX,
      ST_SCORE,
      ST_DONE
   } state_type;

   // ------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------
   state_type               state_ff, state_in;
   logic [NODES-1:0]        valid_ff, valid_in;
   logic                    has_focus_ff, has_focus_in;
   logic [IDX_BITS-1:0]     focused_ff, focused_in;
   logic [DIR_W-1:0]        dir_ff, dir_in;
   logic                    cur_ff, cur_in;
   logic [CNT_BITS-1:0]     scan_ff, scan_in;
   logic                    p1_vld_ff, p1_vld_in;
   logic [IDX_BITS-1:0]     p1_idx_ff, p1_idx_in;
   logic                    p2_vld_ff, p2_vld_in;
   logic [IDX_BITS-1:0]     p2_idx_ff, p2_idx_in;
   logic                    p3_vld_ff, p3_vld_in;
   logic [IDX_BITS-1:0]     p3_idx_ff, p3_idx_in;
   logic                    bb_any_ff, bb_any_in;
   logic                    found_ff, found_in;
   logic                    res_changed_ff, res_changed_in;
   logic                    res_move_ff, res_move_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_fv_ff, rsp_fv_in;
   logic [INDEX_W-1:0]      rsp_slot_ff, rsp_slot_in;
   logic                    rsp_chg_ff, rsp_chg_in;
   logic                    rsp_done_ff, rsp_done_in;

   // payload registers (no reset)
   logic [CW-1:0]           minx_ff, minx_in, miny_ff, miny_in;
   logic [CW:0]             maxx_ff, maxx_in, maxy_ff, maxy_in;
   logic [OW-1:0]           ox_ff, ox_in, oy_ff, oy_in;
   logic signed [DW-1:0]    cx_ff, cx_in, cy_ff, cy_in;
   logic [SW-1:0]           sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [SCW-1:0]          best_score_ff, best_score_in;
   logic [IDX_BITS-1:0]     best_ff, best_in;

   // rectangle memory: {pos_x, pos_y, size_x, size_y}
   logic [RECT_W-1:0]       rect_mem [NODES];
   logic [RECT_W-1:0]       rd_data_ff;
   logic [IDX_BITS-1:0]     rd_addr;
   logic                    mem_we;
   logic [IDX_BITS-1:0]     mem_wa;
   logic [RECT_W-1:0]       mem_wd;

   // ------------------------------------------------------------------
   // combinational helpers
   // ------------------------------------------------------------------
   logic                    accept;
   logic                    idx_ok;
   logic [IDX_BITS-1:0]     slot;
   logic                    slot_focused;
   logic                    any_valid;
   logic                    issuing;
   logic [IDX_BITS-1:0]     scan_idx;
   logic                    vertical;
   logic [CW-1:0]           rd_px, rd_py, rd_sx, rd_sy;
   logic [OW-1:0]           rd_cx, rd_cy;
   logic [CW:0]             rd_ex, rd_ey;
   logic                    ahead;
   logic signed [2*DW-1:0]  prod_x, prod_y;
   logic [SCW-1:0]          score;
   logic                    out_free;

   assign accept       = req_valid && !req_stall;
   assign req_stall    = (state_ff != ST_IDLE);
   assign idx_ok       = (9'(req_entry_index) < 9'(NODES));
   assign slot         = IDX_BITS'(req_entry_index);
   assign slot_focused = has_focus_ff && (focused_ff == slot);
   assign any_valid    = |valid_ff;
   assign scan_idx     = scan_ff[IDX_BITS-1:0];
   assign issuing      = ((state_ff == ST_BBOX) || (state_ff == ST_SCORE))
                         && (scan_ff != CNT_BITS'(NODES));
   assign vertical     = (dir_ff == DIR_UP) || (dir_ff == DIR_DOWN);
   assign out_free     = !rsp_valid_ff || !rsp_stall;

   // read port: focused slot while idle, scan slot otherwise
   assign rd_addr = (state_ff == ST_IDLE) ? focused_ff : scan_idx;

   // unpack the read word
   assign rd_px = rd_data_ff[4*CW-1:3*CW];
   assign rd_py = rd_data_ff[3*CW-1:2*CW];
   assign rd_sx = rd_data_ff[2*CW-1:CW];
   assign rd_sy = rd_data_ff[CW-1:0];

   // doubled centres and far edges
   assign rd_cx = {1'b0, rd_px, 1'b0} + OW'(rd_sx);
   assign rd_cy = {1'b0, rd_py, 1'b0} + OW'(rd_sy);
   assign rd_ex = {1'b0, rd_px} + {1'b0, rd_sx};
   assign rd_ey = {1'b0, rd_py} + {1'b0, rd_sy};

   // squares of the registered offsets
   assign prod_x = cx_ff * cx_ff;
   assign prod_y = cy_ff * cy_ff;

   // score weights the off-axis offset twice
   assign score = vertical ? ({1'b0, sqx_ff, 1'b0} + SCW'(sqy_ff))
                           : (SCW'(sqx_ff) + {1'b0, sqy_ff, 1'b0});

   // ------------------------------------------------------------------
   // next state
   // ------------------------------------------------------------------
   always_comb begin
      state_in       = state_ff;
      valid_in       = valid_ff;
      has_focus_in   = has_focus_ff;
      focused_in     = focused_ff;
      dir_in         = dir_ff;
      cur_in         = cur_ff;
      scan_in        = scan_ff;
      bb_any_in      = bb_any_ff;
      found_in       = found_ff;
      res_changed_in = res_changed_ff;
      res_move_in    = res_move_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_fv_in      = rsp_fv_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_chg_in     = rsp_chg_ff;
      rsp_done_in    = rsp_done_ff;
      minx_in        = minx_ff;
      miny_in        = miny_ff;
      maxx_in        = maxx_ff;
      maxy_in        = maxy_ff;
      ox_in          = ox_ff;
      oy_in          = oy_ff;
      best_score_in  = best_score_ff;
      best_in        = best_ff;
      mem_we         = 1'b0;
      mem_wa         = slot;
      mem_wd         = {req_pos_x, req_pos_y, req_size_x, req_size_y};
      ahead          = 1'b0;

      // scan issue: one slot read per cycle
      p1_vld_in = issuing && valid_ff[scan_idx]
                  && !(cur_ff && (state_ff == ST_SCORE) && (scan_idx == focused_ff));
      p1_idx_in = scan_idx;
      if (issuing) begin
         scan_in = scan_ff + 1'b1;
      end

      // score stage 1: offsets from origin and ahead test
      cx_in = $signed({1'b0, rd_cx}) - $signed({1'b0, ox_ff});
      cy_in = $signed({1'b0, rd_cy}) - $signed({1'b0, oy_ff});
      case (dir_ff)
         DIR_UP:    ahead = cy_in[DW-1];
         DIR_DOWN:  ahead = !cy_in[DW-1] && (cy_in != '0);
         DIR_LEFT:  ahead = cx_in[DW-1];
         default:   ahead = !cx_in[DW-1] && (cx_in != '0);
      endcase
      p2_vld_in = p1_vld_ff && ahead && (state_ff == ST_SCORE);
      p2_idx_in = p1_idx_ff;

      // score stage 2: squares
      p3_vld_in = p2_vld_ff;
      p3_idx_in = p2_idx_ff;
      sqx_in    = prod_x[SW-1:0];
      sqy_in    = prod_y[SW-1:0];

      // score stage 3: keep the lowest, earlier slot wins a tie
      if (p3_vld_ff && (!found_ff || (score < best_score_ff))) begin
         found_in      = 1'b1;
         best_score_in = score;
         best_in       = p3_idx_ff;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_changed_in = 1'b0;
               res_move_in    = 1'b0;
               state_in       = ST_DONE;
               case (req_command)
                  CMD_REGISTER: begin
                     if (idx_ok) begin
                        mem_we         = 1'b1;
                        valid_in[slot] = 1'b1;
                     end
                  end
                  CMD_UNREGISTER: begin
                     if (idx_ok) begin
                        valid_in[slot] = 1'b0;
                        if (slot_focused) begin
                           has_focus_in = 1'b0;
                           focused_in   = '0;
                        end
                     end
                  end
                  CMD_SET_RECT: begin
                     if (idx_ok && valid_ff[slot]) begin
                        mem_we = 1'b1;
                     end
                  end
                  CMD_SET_FOCUS: begin
                     if (idx_ok && valid_ff[slot] && !slot_focused) begin
                        has_focus_in   = 1'b1;
                        focused_in     = slot;
                        res_changed_in = 1'b1;
                     end
                  end
                  CMD_CLEAR: begin
                     valid_in     = '0;
                     has_focus_in = 1'b0;
                     focused_in   = '0;
                  end
                  CMD_MOVE: begin
                     dir_in    = req_direction;
                     cur_in    = has_focus_ff && valid_ff[focused_ff];
                     scan_in   = '0;
                     bb_any_in = 1'b0;
                     found_in  = 1'b0;
                     if ((req_direction <= DIR_RIGHT) && any_valid) begin
                        // focused rect is read this cycle
                        state_in = (has_focus_ff && valid_ff[focused_ff])
                                   ? ST_ORIGIN : ST_BBOX;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ORIGIN: begin
            ox_in    = rd_cx;
            oy_in    = rd_cy;
            state_in = ST_SCORE;
         end
         ST_BBOX: begin
            // grow the bounding box with each valid slot
            if (p1_vld_ff) begin
               bb_any_in = 1'b1;
               if (!bb_any_ff || (rd_px < minx_ff)) minx_in = rd_px;
               if (!bb_any_ff || (rd_py < miny_ff)) miny_in = rd_py;
               if (!bb_any_ff || (rd_ex > maxx_ff)) maxx_in = rd_ex;
               if (!bb_any_ff || (rd_ey > maxy_ff)) maxy_in = rd_ey;
            end
            if (!issuing && !p1_vld_ff) begin
               ox_in    = OW'(minx_ff) + OW'(maxx_ff);
               oy_in    = OW'(miny_ff) + OW'(maxy_ff);
               scan_in  = '0;
               state_in = ST_SCORE;
            end
         end
         ST_SCORE: begin
            if (!issuing && !p1_vld_ff && !p2_vld_ff && !p3_vld_ff) begin
               if (found_ff) begin
                  res_move_in = 1'b1;
                  if (!(has_focus_ff && (focused_ff == best_ff))) begin
                     has_focus_in   = 1'b1;
                     focused_in     = best_ff;
                     res_changed_in = 1'b1;
                  end
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hand the word to the output register once it is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_fv_in    = has_focus_ff;
               rsp_slot_in  = has_focus_ff ? INDEX_W'(focused_ff) : '0;
               rsp_chg_in   = res_changed_ff;
               rsp_done_in  = res_move_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // control state and registered outputs
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         valid_ff       <= '0;
         has_focus_ff   <= 1'b0;
         focused_ff     <= '0;
         dir_ff         <= '0;
         cur_ff         <= 1'b0;
         scan_ff        <= '0;
         p1_vld_ff      <= 1'b0;
         p2_vld_ff      <= 1'b0;
         p3_vld_ff      <= 1'b0;
         bb_any_ff      <= 1'b0;
         found_ff       <= 1'b0;
         res_changed_ff <= 1'b0;
         res_move_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         rsp_fv_ff      <= 1'b0;
         rsp_slot_ff    <= '0;
         rsp_chg_ff     <= 1'b0;
         rsp_done_ff    <= 1'b0;
      end else begin
         state_ff       <= state_in;
         valid_ff       <= valid_in;
         has_focus_ff   <= has_focus_in;
         focused_ff     <= focused_in;
         dir_ff         <= dir_in;
         cur_ff         <= cur_in;
         scan_ff        <= scan_in;
         p1_vld_ff      <= p1_vld_in;
         p2_vld_ff      <= p2_vld_in;
         p3_vld_ff      <= p3_vld_in;
         bb_any_ff      <= bb_any_in;
         found_ff       <= found_in;
         res_changed_ff <= res_changed_in;
         res_move_ff    <= res_move_in;
         rsp_valid_ff   <= rsp_valid_in;
         rsp_fv_ff      <= rsp_fv_in;
         rsp_slot_ff    <= rsp_slot_in;
         rsp_chg_ff     <= rsp_chg_in;
         rsp_done_ff    <= rsp_done_in;
      end
   end

   // ------------------------------------------------------------------
   // datapath payload
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      p1_idx_ff     <= p1_idx_in;
      p2_idx_ff     <= p2_idx_in;
      p3_idx_ff     <= p3_idx_in;
      minx_ff       <= minx_in;
      miny_ff       <= miny_in;
      maxx_ff       <= maxx_in;
      maxy_ff       <= maxy_in;
      ox_ff         <= ox_in;
      oy_ff         <= oy_in;
      cx_ff         <= cx_in;
      cy_ff         <= cy_in;
      sqx_ff        <= sqx_in;
      sqy_ff        <= sqy_in;
      best_score_ff <= best_score_in;
      best_ff       <= best_in;
   end

   // ------------------------------------------------------------------
   // rectangle memory, one write and one registered read port; writes
   // only happen on acceptance and the done state sits between a write
   // and any later read
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (mem_we) begin
         rect_mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= rect_mem[rd_addr];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_focus_valid   = rsp_fv_ff;
   assign rsp_focus_slot    = rsp_slot_ff;
   assign rsp_focus_changed = rsp_chg_ff;
   assign rsp_move_done     = rsp_done_ff;

endmodule
